[hdl/triangle_cull_shade_edges_top_defines.svh]
// Assertion macros for the triangle cull and shade block.
`ifndef TRIANGLE_CULL_SHADE_EDGES_TOP_DEFINES_SVH
`define TRIANGLE_CULL_SHADE_EDGES_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCS_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define TCS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define TCS_ASSERT_IMPL(label, clk, rst, a, c, msg)
`define TCS_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

[hdl/tcs_pkg.sv]
// Shared constants and types for the triangle cull and shade block.
package tcs_pkg;
  localparam int VERTEX_COUNT_DEF = 4096;
  localparam int COORD_BITS_DEF = 24;
  localparam int IDX_BITS = 12;
  localparam int CELL_BITS = 32;
  localparam int LIGHT_BITS = 16;
  localparam logic [CELL_BITS-1:0] CELL_NONE = '1;
  localparam int FLAG_AB_BIT = 30;
  localparam int FLAG_BC_BIT = 29;
  localparam int FLAG_CA_BIT = 28;
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;
  localparam logic KIND_TRI = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;
endpackage

[hdl/tcs_vstore.sv]
// Vertex store: one synchronous memory, registered read.
module tcs_vstore #(
  parameter int VERTEX_COUNT = tcs_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_BITS = tcs_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic we,
  input  logic [tcs_pkg::IDX_BITS-1:0] waddr,
  input  logic [3*COORD_BITS-1:0] wdata,
  input  logic [tcs_pkg::IDX_BITS-1:0] raddr,
  output logic [3*COORD_BITS-1:0] rdata
);
  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int IW = tcs_pkg::IDX_BITS;
  logic [3*COORD_BITS-1:0] mem [VERTEX_COUNT];
  logic [IW+AW:0] wa_ext, ra_ext;
  logic [AW-1:0] wa, ra;

  assign wa_ext = {{(AW+1){1'b0}}, waddr};
  assign ra_ext = {{(AW+1){1'b0}}, raddr};
  assign wa = wa_ext[AW-1:0];
  assign ra = ra_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (we && (wa_ext < (IW+AW+1)'(VERTEX_COUNT))) mem[wa] <= wdata;
    rdata <= mem[ra];
    if (!(ra_ext < (IW+AW+1)'(VERTEX_COUNT))) rdata <= '0;
  end
endmodule

[hdl/tcs_divsqrt.sv]
// Sequential fraction and square root unit for lightness.
module tcs_divsqrt (
  input  logic clk,
  input  logic rst,
  input  tcs_pkg::div_req_t req,
  output logic busy,
  output logic done,
  output logic [tcs_pkg::LIGHT_BITS-1:0] light
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  logic [1:0] state;
  logic [6:0] cnt;
  logic [63:0] rem, den, quo, num;
  logic [33:0] root;
  logic [35:0] srem;
  logic [64:0] trial;
  logic [35:0] strial;

  // restoring division gives floor(2^32 * num / den), 96 steps (num <= den)
  assign trial = {rem, num[63]} - {1'b0, den};
  assign strial = {srem[33:0], quo[63:62]} - {root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            rem <= '0; num <= req.num; den <= req.den; quo <= '0;
            cnt <= 7'd96; state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[64]) begin
            rem <= trial[63:0]; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], num[63]}; quo <= {quo[62:0], 1'b0};
          end
          num <= {num[62:0], 1'b0};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_SQRT; cnt <= 7'd32; root <= '0; srem <= '0;
          end
        end
        S_SQRT: begin
          if (!strial[35]) begin
            srem <= strial; root <= {root[32:0], 1'b1};
          end else begin
            srem <= {srem[33:0], quo[63:62]}; root <= {root[32:0], 1'b0};
          end
          quo <= {quo[61:0], 2'b00};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_IDLE; done <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign light = (root[32:16] != '0) ? '1 : root[15:0];
endmodule

[hdl/triangle_cull_shade_edges_top.sv]
// Top level of the triangle cull and shade block.
// Usage: one input channel (in_valid/in_ready) carries vertex writes and
// triangle requests; one output channel (out_valid/out_ready) carries
// shapes. A vertex transaction writes the vertex store and produces
// nothing, so vertex transactions can follow back to back. A triangle
// with both or neither cell word valid is dropped at acceptance. Any
// other triangle reads its three corners through one memory read port,
// forms edges, the cross product on one shared multiplier and the normal,
// then runs the cull test, scaling and squaring; a culled one returns to
// idle and frees the input. A kept triangle then runs the lightness unit
// (start cycle, 96-step division, 32-step square root, hand-off cycle),
// which a degenerate normal skips. Results follow one per cycle while the
// receiver takes them: the triangle, then a line for each set edge flag,
// last marking the final one. One triangle is worked at a time; the input
// is held off until all its results are taken. Out-of-range indices read
// as zero, writes to them are dropped. Reset (rst, synchronous) returns
// control to idle; the vertex store is not cleared. When the receiver
// stalls, the current result is held unchanged and the block waits.
`include "triangle_cull_shade_edges_top_defines.svh"
module triangle_cull_shade_edges_top #(
  parameter int VERTEX_COUNT = tcs_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_BITS = tcs_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [tcs_pkg::IDX_BITS-1:0] vertex_index,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic [tcs_pkg::IDX_BITS-1:0] corner_a,
  input  logic [tcs_pkg::IDX_BITS-1:0] corner_b,
  input  logic [tcs_pkg::IDX_BITS-1:0] corner_c,
  input  logic [tcs_pkg::CELL_BITS-1:0] cell_front,
  input  logic [tcs_pkg::CELL_BITS-1:0] cell_back,
  output logic out_valid,
  input  logic out_ready,
  output logic shape_kind,
  output logic pen,
  output logic [tcs_pkg::LIGHT_BITS-1:0] lightness,
  output logic [tcs_pkg::IDX_BITS-1:0] index_a,
  output logic [tcs_pkg::IDX_BITS-1:0] index_b,
  output logic [tcs_pkg::IDX_BITS-1:0] index_c,
  output logic signed [COORD_BITS-1:0] depth,
  output logic last
);
  localparam int CB = COORD_BITS;
  localparam int SH = (CB > 30) ? CB - 30 : 0;
  localparam int EB = CB + 1 - SH;   // edge width
  localparam int PB = 2 * EB;        // product width
  localparam int NB = PB + 1;        // normal width
  localparam int IW = tcs_pkg::IDX_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_EDGE = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_NORM = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;

  logic [3:0] state;
  logic [2:0] cnt;
  logic [IW-1:0] ia, ib, ic;
  logic flip;
  logic [2:0] flags;
  logic [IW-1:0] raddr;
  logic [3*CB-1:0] rdata;
  logic signed [CB-1:0] pa [3];
  logic signed [CB-1:0] pb [3];
  logic signed [CB-1:0] pc [3];
  logic signed [EB-1:0] e1 [3];
  logic signed [EB-1:0] e2 [3];
  logic signed [PB-1:0] prod [6];
  logic signed [NB-1:0] nvec [3];
  logic [NB-1:0] amag [3];
  logic [19:0] m20 [3];
  logic [39:0] sq [3];
  logic signed [EB-1:0] mul_a, mul_b;
  logic signed [PB-1:0] mul_p;
  logic signed [CB-1:0] zmin, ldepth;
  logic [3:0] pend;
  tcs_pkg::div_req_t dreq;
  logic dbusy, ddone;
  logic [tcs_pkg::LIGHT_BITS-1:0] dlight;
  logic [tcs_pkg::LIGHT_BITS-1:0] light_r;
  logic fv, bv;

  tcs_vstore #(.VERTEX_COUNT(VERTEX_COUNT), .COORD_BITS(COORD_BITS)) u_store (
    .clk(clk), .we(in_valid && in_ready && req_type == tcs_pkg::REQ_VERTEX),
    .waddr(vertex_index), .wdata({pos_z, pos_y, pos_x}),
    .raddr(raddr), .rdata(rdata));

  tcs_divsqrt u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy),
                     .done(ddone), .light(dlight));

  assign in_ready = (state == ST_IDLE);
  assign fv = (cell_front != tcs_pkg::CELL_NONE);
  assign bv = (cell_back != tcs_pkg::CELL_NONE);

  // read address walks a, b, c during the read phase
  always_comb begin
    case (cnt)
      3'd0: raddr = ia;
      3'd1: raddr = ib;
      default: raddr = ic;
    endcase
  end

  // one shared multiplier for the six cross product terms
  always_comb begin
    case (cnt)
      3'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
  end
  assign mul_p = PB'(mul_a * mul_b);

  function automatic logic [NB-1:0] fmag(input logic signed [NB-1:0] v);
    fmag = v[NB-1] ? NB'(-v) : NB'(v);
  endfunction

  // normalize magnitudes: shift together until all below 2^20
  logic [NB-1:0] mx;
  logic [6:0] shamt;
  always_comb begin
    mx = amag[0] | amag[1] | amag[2];
    shamt = '0;
    for (int i = 0; i < NB; i++) begin
      if (mx[i] && i >= 20) shamt = 7'(i - 19);
    end
  end

  assign ldepth = (zmin == {1'b1, {(CB-1){1'b0}}}) ? zmin : zmin - CB'(1);

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && req_type == tcs_pkg::REQ_TRIANGLE) begin
            ia <= corner_a; ib <= corner_b; ic <= corner_c;
            flip <= !fv;
            flags <= fv ? {cell_front[tcs_pkg::FLAG_AB_BIT], cell_front[tcs_pkg::FLAG_BC_BIT],
                           cell_front[tcs_pkg::FLAG_CA_BIT]}
                        : {cell_back[tcs_pkg::FLAG_AB_BIT], cell_back[tcs_pkg::FLAG_BC_BIT],
                           cell_back[tcs_pkg::FLAG_CA_BIT]};
            cnt <= '0;
            if (fv != bv) state <= ST_RD;
          end
        end
        ST_RD: begin
          // data for the address issued last cycle arrives now
          if (cnt != 3'd0) begin
            for (int k = 0; k < 3; k++) begin
              if (cnt == 3'd1) pa[k] <= rdata[k*CB +: CB];
              else if (cnt == 3'd2) pb[k] <= rdata[k*CB +: CB];
            end
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            for (int k = 0; k < 3; k++) pc[k] <= rdata[k*CB +: CB];
            state <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            e1[k] <= EB'(($signed({pb[k][CB-1], pb[k]}) - $signed({pa[k][CB-1], pa[k]})) >>> SH);
            e2[k] <= EB'(($signed({pc[k][CB-1], pc[k]}) - $signed({pa[k][CB-1], pa[k]})) >>> SH);
          end
          zmin <= (pa[2] <= pb[2] && pa[2] <= pc[2]) ? pa[2] :
                  (pb[2] <= pc[2]) ? pb[2] : pc[2];
          cnt <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod[cnt] <= mul_p;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) state <= ST_NORM;
        end
        ST_NORM: begin
          for (int k = 0; k < 3; k++) begin
            logic signed [NB-1:0] d;
            d = NB'(prod[2*k]) - NB'(prod[2*k+1]);
            nvec[k] <= flip ? NB'(-d) : d;
          end
          state <= ST_SQ;
          cnt <= '0;
        end
        ST_SQ: begin
          // cull test and magnitudes, then shift, then squares, then division start or zero-normal skip
          cnt <= cnt + 3'd1;
          case (cnt)
            3'd0: begin
              if (nvec[2][NB-1]) state <= ST_IDLE;
              for (int k = 0; k < 3; k++) amag[k] <= fmag(nvec[k]);
            end
            3'd1: begin
              for (int k = 0; k < 3; k++) m20[k] <= 20'(amag[k] >> shamt);
            end
            3'd2: begin
              for (int k = 0; k < 3; k++) sq[k] <= m20[k] * m20[k];
            end
            default: begin
              if ((amag[0] | amag[1] | amag[2]) == '0) begin
                light_r <= '0; state <= ST_EMIT;
                pend <= {flags, 1'b1}; out_valid <= 1'b0;
              end else begin
                dreq.start <= 1'b1;
                dreq.num <= {24'd0, sq[2]};
                dreq.den <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
                state <= ST_DIV;
              end
            end
          endcase
        end
        ST_DIV: begin
          if (ddone) begin
            light_r <= dlight; state <= ST_EMIT;
            pend <= {flags, 1'b1}; out_valid <= 1'b0;
          end
        end
        ST_EMIT: begin
          // load next pending shape when output is free, or return to idle when none is left
          if (!out_valid || out_ready) begin
            if (pend == '0) begin
              out_valid <= 1'b0;
              state <= ST_IDLE;
            end else begin
              out_valid <= 1'b1;
              if (pend[0]) begin
                shape_kind <= tcs_pkg::KIND_TRI; pen <= 1'b0; lightness <= light_r;
                index_a <= ia; index_b <= ib; index_c <= ic; depth <= zmin;
                pend[0] <= 1'b0; last <= (pend[3:1] == '0);
              end else begin
                shape_kind <= tcs_pkg::KIND_LINE; pen <= 1'b1; lightness <= '0;
                index_c <= '0; depth <= ldepth;
                if (pend[3]) begin
                  index_a <= ia; index_b <= ib; pend[3] <= 1'b0;
                  last <= (pend[2:1] == '0);
                end else if (pend[2]) begin
                  index_a <= ib; index_b <= ic; pend[2] <= 1'b0;
                  last <= !pend[1];
                end else begin
                  index_a <= ic; index_b <= ia; pend[1] <= 1'b0; last <= 1'b1;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TCS_ASSERT_IMPL(a_out_only_emit, clk, rst, out_valid, state == ST_EMIT,
                   "result shown outside emit phase")
  `TCS_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(index_a) && $stable(depth), "stalled result changed")
  `TCS_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ready,
                   "input accepted while busy")
  `TCS_ASSERT_IMPL(a_div_in_div, clk, rst, dbusy, state == ST_DIV,
                   "lightness unit busy outside its phase")
endmodule
